### rtl/cflp_pkg.sv
// Package: shared types, codes and functions of the framed line parser.
`timescale 1ns / 1ps
`default_nettype none
package cflp_pkg;

    localparam logic [7:0]  CH_COLON  = 8'h3A;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_MINUS  = 8'h2D;
    localparam logic [7:0]  CH_0      = 8'h30;
    localparam logic [7:0]  CH_9      = 8'h39;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] MAX_PAY_RESET = 16'd1024;
    localparam int          Q_DEPTH   = 4;
    localparam int          Q_PTR_W   = $clog2(Q_DEPTH);

    // Error flag bit positions
    localparam int ERR_STRUCT = 0;
    localparam int ERR_MINUS  = 1;
    localparam int ERR_PARSE  = 2;
    localparam int ERR_LENGTH = 3;
    localparam int ERR_TRAIL  = 4;
    localparam int ERR_CHECK  = 5;
    localparam int ERR_TYPE   = 6;
    localparam int ERR_W      = 7;

    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0,
        PH_TYPE  = 3'd1,
        PH_LEN   = 3'd2,
        PH_CRC   = 3'd3,
        PH_PAY   = 3'd4,
        PH_TRAIL = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TYPE    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HEADER  = 3'd1,
        ST_LENGTH  = 3'd2,
        ST_TRAILER = 3'd3,
        ST_CRC     = 3'd4,
        ST_TYPE    = 3'd5
    } t_status;

    // One queue entry: an optional passed-through byte and an optional status.
    typedef struct packed {
        logic        has_byte;
        t_kind       byte_kind;
        logic [7:0]  data;
        logic        has_status;
        t_status     status;
        logic [15:0] count;
    } t_q_entry;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] v;
        v = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

    // Returns {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        return {1'b0, t[3:0]};
    endfunction

    function automatic logic [7:0] magic_char(input logic [1:0] idx);
        case (idx)
            2'd0:    magic_char = 8'h50;
            2'd1:    magic_char = 8'h56;
            2'd2:    magic_char = 8'h31;
            default: magic_char = 8'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

### rtl/cflp_if.sv
// Interfaces: input byte channel and result item channel.
`timescale 1ns / 1ps
`default_nettype none
interface cflp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       line_end;

    modport source (output valid, output in_byte, output line_end, input ready);
    modport sink   (input valid, input in_byte, input line_end, output ready);
endinterface

interface cflp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [15:0] field_count;
    logic        frame_last;

    modport source (output valid, output kind, output out_byte, output status,
                    output field_count, output frame_last, input ready);
    modport sink   (input valid, input kind, input out_byte, input status,
                    input field_count, input frame_last, output ready);
endinterface
`default_nettype wire

### rtl/cflp_front.sv
// Front end: accepts line bytes, tracks fields and checks, builds queue entries.
`timescale 1ns / 1ps
`default_nettype none
module cflp_front #(
    parameter int LENGTH_BITS = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [15:0]        i_cfg_data,
    cflp_in_if.sink           i_in,
    input  wire               i_full,
    output logic              o_push,
    output cflp_pkg::t_q_entry o_entry
);
    import cflp_pkg::*;

    t_phase                   r_phase, n_phase;
    logic [2:0]               r_byte_index, n_byte_index;
    logic [2:0]               r_digit_count, n_digit_count;
    logic [LENGTH_BITS-1:0]   r_len, n_len;
    logic [15:0]              r_exp, n_exp;
    logic [15:0]              r_crc, n_crc;
    logic [15:0]              r_left, n_left;
    logic [ERR_W-1:0]         r_err, n_err;
    logic [15:0]              r_max_payload;

    logic                     w_accept;
    logic [7:0]               c;
    logic                     w_colon;
    logic [LENGTH_BITS+3:0]   w_len_ext;
    logic [LENGTH_BITS+3:0]   w_len_x10;
    logic                     w_len_big;
    logic [4:0]               w_hex;
    logic [ERR_W-1:0]         w_flags;
    t_status                  w_status;

    assign i_in.ready = ~i_full;
    assign w_accept   = i_in.valid & ~i_full;
    assign c          = i_in.in_byte;
    assign w_colon    = (c == CH_COLON);
    assign w_len_ext  = {4'b0000, r_len};
    assign w_len_x10  = (w_len_ext << 3) + (w_len_ext << 1) + {{LENGTH_BITS{1'b0}}, c[3:0]};
    assign w_len_big  = {1'b0, r_len} > (LENGTH_BITS + 1)'(17'h0FFFF);
    assign w_hex      = hex_value(c);

    always_comb begin
        n_phase       = r_phase;
        n_byte_index  = r_byte_index;
        n_digit_count = r_digit_count;
        n_len         = r_len;
        n_exp         = r_exp;
        n_crc         = r_crc;
        n_left        = r_left;
        n_err         = r_err;
        o_entry       = '0;
        w_flags       = '0;
        w_status      = ST_OK;

        case (r_phase)
            PH_MAGIC: begin
                if (w_colon) begin
                    if (r_byte_index != 3'd3) n_err[ERR_STRUCT] = 1'b1;
                    n_phase       = PH_TYPE;
                    n_digit_count = 3'd0;
                end else begin
                    if (r_byte_index >= 3'd3 || c != magic_char(r_byte_index[1:0])) begin
                        n_err[ERR_STRUCT] = 1'b1;
                    end
                    if (r_byte_index < 3'd4) n_byte_index = r_byte_index + 3'd1;
                end
            end
            PH_TYPE: begin
                n_crc = crc_byte(r_crc, c);
                if (w_colon) begin
                    n_phase       = PH_LEN;
                    n_digit_count = 3'd0;
                end else begin
                    if (c[7]) n_err[ERR_TYPE] = 1'b1;
                    o_entry.has_byte  = 1'b1;
                    o_entry.byte_kind = KIND_TYPE;
                    o_entry.data      = c;
                end
            end
            PH_LEN: begin
                if (w_colon) begin
                    if (r_digit_count == 3'd0) n_err[ERR_PARSE] = 1'b1;
                    n_phase       = PH_CRC;
                    n_digit_count = 3'd0;
                end else begin
                    if (r_digit_count == 3'd0 && c == CH_MINUS) n_err[ERR_MINUS] = 1'b1;
                    if (!(c inside {[CH_0:CH_9]})) begin
                        n_err[ERR_PARSE] = 1'b1;
                    end else if (!r_err[ERR_PARSE]) begin
                        // Overflow when the scaled value no longer fits
                        if (|w_len_x10[LENGTH_BITS+3:LENGTH_BITS]) begin
                            n_err[ERR_PARSE] = 1'b1;
                        end else begin
                            n_len = w_len_x10[LENGTH_BITS-1:0];
                        end
                    end
                    if (r_digit_count < 3'd7) n_digit_count = r_digit_count + 3'd1;
                end
            end
            PH_CRC: begin
                if (w_colon) begin
                    if (r_digit_count == 3'd0 || r_digit_count > 3'd4) n_err[ERR_PARSE] = 1'b1;
                    if (r_len > LENGTH_BITS'(r_max_payload)) n_err[ERR_LENGTH] = 1'b1;
                    n_left        = w_len_big ? 16'hFFFF : r_len[15:0];
                    n_phase       = (n_left != 16'd0) ? PH_PAY : PH_TRAIL;
                    n_digit_count = 3'd0;
                end else begin
                    if (!w_hex[4]) n_err[ERR_PARSE] = 1'b1;
                    else           n_exp = {r_exp[11:0], w_hex[3:0]};
                    if (r_digit_count < 3'd7) n_digit_count = r_digit_count + 3'd1;
                end
            end
            PH_PAY: begin
                n_crc             = crc_byte(r_crc, c);
                o_entry.has_byte  = 1'b1;
                o_entry.byte_kind = KIND_PAYLOAD;
                o_entry.data      = c;
                n_left            = r_left - 16'd1;
                if (n_left == 16'd0) n_phase = PH_TRAIL;
            end
            default: begin
                if (c != CH_SPACE) n_err[ERR_TRAIL] = 1'b1;
            end
        endcase

        // Judge the line on its final byte
        w_flags = n_err;
        if (n_phase inside {PH_MAGIC, PH_TYPE, PH_LEN, PH_CRC}) w_flags[ERR_STRUCT] = 1'b1;
        if (n_phase == PH_PAY) w_flags[ERR_LENGTH] = 1'b1;
        if (n_crc != n_exp)    w_flags[ERR_CHECK]  = 1'b1;

        if (w_flags[ERR_STRUCT])      w_status = ST_HEADER;
        else if (w_flags[ERR_MINUS])  w_status = ST_LENGTH;
        else if (w_flags[ERR_PARSE])  w_status = ST_HEADER;
        else if (w_flags[ERR_LENGTH]) w_status = ST_LENGTH;
        else if (w_flags[ERR_TRAIL])  w_status = ST_TRAILER;
        else if (w_flags[ERR_CHECK])  w_status = ST_CRC;
        else if (w_flags[ERR_TYPE])   w_status = ST_TYPE;
        else                          w_status = ST_OK;

        if (i_in.line_end) begin
            o_entry.has_status = 1'b1;
            o_entry.status     = w_status;
            o_entry.count      = (w_status == ST_OK) ? n_len[15:0] : 16'd0;
            n_phase            = PH_MAGIC;
            n_byte_index       = 3'd0;
            n_digit_count      = 3'd0;
            n_len              = '0;
            n_exp              = 16'd0;
            n_crc              = CRC_INIT;
            n_left             = 16'd0;
            n_err              = '0;
        end
    end

    assign o_push = w_accept & (o_entry.has_byte | o_entry.has_status);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MAGIC;
            r_byte_index  <= 3'd0;
            r_digit_count <= 3'd0;
            r_len         <= '0;
            r_exp         <= 16'd0;
            r_crc         <= CRC_INIT;
            r_left        <= 16'd0;
            r_err         <= '0;
        end else if (w_accept) begin
            r_phase       <= n_phase;
            r_byte_index  <= n_byte_index;
            r_digit_count <= n_digit_count;
            r_len         <= n_len;
            r_exp         <= n_exp;
            r_crc         <= n_crc;
            r_left        <= n_left;
            r_err         <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAY_RESET;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_data;
        end
    end

endmodule
`default_nettype wire

### rtl/cflp_queue.sv
// Queue: short FIFO of entries between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module cflp_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  wire cflp_pkg::t_q_entry i_data,
    input  wire                     i_pop,
    output cflp_pkg::t_q_entry      o_head,
    output logic                    o_empty,
    output logic                    o_full
);
    import cflp_pkg::*;

    t_q_entry           r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               w_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            if (w_pop)  r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + (Q_PTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (Q_PTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/cflp_back.sv
// Back end: splits queue entries into result items and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module cflp_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire cflp_pkg::t_q_entry i_head,
    input  wire                     i_empty,
    output logic                    o_pop,
    cflp_out_if.source              o_out
);
    import cflp_pkg::*;

    logic        r_valid;
    t_kind       r_kind;
    logic [7:0]  r_byte;
    t_status     r_status;
    logic [15:0] r_count;
    logic        r_last;
    logic        r_byte_done;

    logic        w_load;
    logic        w_take_byte;

    assign w_load      = ~i_empty & (~r_valid | o_out.ready);
    // Byte half goes first; the status half follows from the same entry
    assign w_take_byte = i_head.has_byte & ~r_byte_done;
    assign o_pop       = w_load & ~(w_take_byte & i_head.has_status);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_byte_done <= 1'b0;
        end else if (w_load) begin
            r_valid     <= 1'b1;
            r_byte_done <= w_take_byte & i_head.has_status;
        end else if (o_out.ready) begin
            r_valid     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_take_byte) begin
                r_kind   <= i_head.byte_kind;
                r_byte   <= i_head.data;
                r_status <= ST_OK;
                r_count  <= 16'd0;
                r_last   <= 1'b0;
            end else begin
                r_kind   <= KIND_STATUS;
                r_byte   <= 8'h00;
                r_status <= i_head.status;
                r_count  <= i_head.count;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_kind;
    assign o_out.out_byte    = r_byte;
    assign o_out.status      = r_status;
    assign o_out.field_count = r_count;
    assign o_out.frame_last  = r_last;

endmodule
`default_nettype wire

### rtl/crc_framed_line_parser.sv
// Top level: framed text line parser with CRC-16 check.
//
// Usage: feed one raw byte of a line per transaction on i_in (in_byte, with
// line_end set on the final byte). Lines look like PV1:type:len:crc:payload
// followed by optional spaces. Type and payload bytes come out on o_out as
// they arrive (kind type or payload), tentatively; the final byte of each
// line also yields one status transaction (kind status, frame_last set) that
// says whether the line was good, plus the payload length when it was.
// Throughput: one input byte per cycle while the queue is not full; every byte
// is classified and the CRC advanced by a byte-wide update in the same cycle.
// A byte that yields two results (a type or payload byte plus status) occupies
// the output twice, which the four-entry queue absorbs.
// Path: the queue is written at the edge that accepts the byte; the output
// register then loads the entry from the queue head and drives o_out, where
// the result waits until the receiver takes it.
// Stall: when the receiver holds ready low the output register holds, the
// queue fills, and i_in.ready drops once the queue is full.
// Reset: synchronous, active low; clears line state, empties the queue and
// sets max_payload to 1024. Write max_payload via i_cfg_we/i_cfg_data only
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module crc_framed_line_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [15:0] i_cfg_data,
    cflp_in_if.sink    i_in,
    cflp_out_if.source o_out
);
    import cflp_pkg::*;

    t_q_entry w_entry;
    t_q_entry w_head;
    logic     w_push;
    logic     w_pop;
    logic     w_empty;
    logic     w_full;

    // Front: parse and classify each byte, push entries
    cflp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    // Queue: decouple parsing from output stalls
    cflp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // Back: expand entries into result transactions
    cflp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
